// File: rtl/teef_pkg.sv
// ----------------------------------------------------------------------------
// teef_pkg: shared types and constants for the tile entropy flagger
// Holds field widths, grid limits, the dimension clamp and the request and
// response structures of the entropy unit.
// ----------------------------------------------------------------------------
package teef_pkg;

  localparam int MAX_TILE_COLS = 32;
  localparam int COL_W         = $clog2(MAX_TILE_COLS);
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;
  localparam int POS_W         = 12;
  localparam int CNT_W         = 25;
  localparam int SUM_W         = CNT_W + 1;
  localparam int ENT_W         = 17;
  localparam int BASE_W        = 18;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;
  localparam int OUT_DATA_W    = 88;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [ENT_W-1:0] ENTROPY_ONE = 17'd65536;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ENT_W-1:0] ent_t;

  typedef struct packed {
    logic start;
    cnt_t zero_count;
    cnt_t nonzero_count;
  } teef_req_t;

  typedef struct packed {
    logic done;
    ent_t entropy;
  } teef_rsp_t;

  // A dimension of zero acts as one; anything above the limit acts as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

endpackage

// File: rtl/teef_mul.sv
// ----------------------------------------------------------------------------
// teef_mul: registered 32 x 32 unsigned multiplier
// The one arithmetic unit shared by every multiply of the entropy sequence.
// ----------------------------------------------------------------------------
module teef_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/teef_entropy.sv
// ----------------------------------------------------------------------------
// teef_entropy: sequenced binary entropy of one tile
// Computes log2 of the total and both counts by repeated squaring on the
// shared multiplier, forms the weighted sum and divides it by the total with
// a restoring divider, then rounds to Q1.16.
// ----------------------------------------------------------------------------
module teef_entropy (
  input  logic               clk,
  input  logic               rst,
  input  teef_pkg::teef_req_t req,
  output teef_pkg::teef_rsp_t rsp
);
  import teef_pkg::*;

  localparam logic [3:0] E_IDLE = 4'd0;
  localparam logic [3:0] E_NORM = 4'd1;
  localparam logic [3:0] E_SQ   = 4'd2;
  localparam logic [3:0] E_SQT  = 4'd3;
  localparam logic [3:0] E_MF   = 4'd4;
  localparam logic [3:0] E_MFT  = 4'd5;
  localparam logic [3:0] E_MK   = 4'd6;
  localparam logic [3:0] E_MKT  = 4'd7;
  localparam logic [3:0] E_ACC  = 4'd8;
  localparam logic [3:0] E_DS   = 4'd9;
  localparam logic [3:0] E_DIV  = 4'd10;
  localparam logic [3:0] E_RND  = 4'd11;

  logic [3:0]       state;
  logic [1:0]       sel;
  logic [SUM_W-1:0] n_val;
  logic [SUM_W-1:0] x_val;
  cnt_t             z_val;
  cnt_t             c_val;
  logic [31:0]      m;
  logic [4:0]       k;
  logic [4:0]       bit_idx;
  logic [31:0]      frac;
  logic [63:0]      part;
  logic [63:0]      term;
  logic [63:0]      total;
  logic [63:0]      parts;
  logic [63:0]      dvd;
  logic [SUM_W-1:0] rem;
  logic [5:0]       div_cnt;
  ent_t             result;
  logic             done;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [32:0] sq;
  logic [SUM_W:0] rem_sh;
  logic [64:0] rounded;
  logic [48:0] scaled;

  teef_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    mul_a = m;
    mul_b = m;
    if (state == E_MF) begin
      mul_a = 32'(x_val);
      mul_b = frac;
    end else if (state == E_MK) begin
      mul_a = 32'(x_val);
      mul_b = 32'(k);
    end
  end

  assign sq      = prod[63:31];
  assign rem_sh  = {rem, dvd[63]};
  assign rounded = {1'b0, dvd} + 65'h8000;
  assign scaled  = rounded[64:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (req.start) begin
            z_val <= req.zero_count;
            c_val <= req.nonzero_count;
            if (req.zero_count == '0 || req.nonzero_count == '0) begin
              result <= '0;
              done   <= 1'b1;
            end else begin
              n_val <= SUM_W'(req.zero_count) + SUM_W'(req.nonzero_count);
              x_val <= SUM_W'(req.zero_count) + SUM_W'(req.nonzero_count);
              m     <= 32'(SUM_W'(req.zero_count) + SUM_W'(req.nonzero_count));
              k     <= 5'd31;
              sel   <= 2'd0;
              total <= '0;
              parts <= '0;
              state <= E_NORM;
            end
          end
        end
        E_NORM: begin
          if (m[31]) begin
            frac    <= '0;
            bit_idx <= 5'd31;
            state   <= E_SQ;
          end else begin
            m <= {m[30:0], 1'b0};
            k <= k - 5'd1;
          end
        end
        E_SQ: state <= E_SQT;
        E_SQT: begin
          if (sq[32]) begin
            frac[bit_idx] <= 1'b1;
            m             <= sq[32:1];
          end else begin
            m <= sq[31:0];
          end
          if (bit_idx == '0) state <= E_MF;
          else begin
            bit_idx <= bit_idx - 5'd1;
            state   <= E_SQ;
          end
        end
        E_MF:  state <= E_MFT;
        E_MFT: begin
          part  <= prod;
          state <= E_MK;
        end
        E_MK:  state <= E_MKT;
        E_MKT: begin
          term  <= part + {prod[31:0], 32'd0};
          state <= E_ACC;
        end
        E_ACC: begin
          if (sel == 2'd0) total <= total + term;
          else             parts <= parts + term;
          if (sel == 2'd2) state <= E_DS;
          else begin
            x_val <= (sel == 2'd0) ? SUM_W'(z_val) : SUM_W'(c_val);
            m     <= (sel == 2'd0) ? 32'(z_val) : 32'(c_val);
            k     <= 5'd31;
            sel   <= sel + 2'd1;
            state <= E_NORM;
          end
        end
        E_DS: begin
          if (parts >= total) begin
            result <= '0;
            done   <= 1'b1;
            state  <= E_IDLE;
          end else begin
            dvd     <= total - parts;
            rem     <= '0;
            div_cnt <= 6'd63;
            state   <= E_DIV;
          end
        end
        E_DIV: begin
          if (rem_sh >= {1'b0, n_val}) begin
            rem <= SUM_W'(rem_sh - {1'b0, n_val});
            dvd <= {dvd[62:0], 1'b1};
          end else begin
            rem <= rem_sh[SUM_W-1:0];
            dvd <= {dvd[62:0], 1'b0};
          end
          if (div_cnt == '0) state <= E_RND;
          else div_cnt <= div_cnt - 6'd1;
        end
        E_RND: begin
          result <= (scaled > 49'(ENTROPY_ONE)) ? ENTROPY_ONE : scaled[ENT_W-1:0];
          done   <= 1'b1;
          state  <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.entropy = result;

endmodule

// File: rtl/tile_binary_entropy_flagger.sv
// ----------------------------------------------------------------------------
// tile_binary_entropy_flagger: per-tile binary entropy of zero pixels
// Counts zero and nonzero pixels per tile column of a configurable grid and,
// at the end of each tile band, reports one result per tile with its counts,
// its binary entropy in Q1.16 and a threshold flag.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   s_*       in         tdata[7:0] = pixel
//   m_*       out        tdata = tile_row, tile_col, zero_count, nonzero_count,
//                        entropy, over_threshold (low bit up); tlast = last
//   cfg_*     in         cfg_index selects the register, cfg_data is the value
//
// A pixel that does not close a band leaves the input ready for the next. A
// pixel that closes a band starts the emission: for each tile the entropy
// unit runs three logarithms, each a normalize and 32 squaring steps on the
// shared multiplier, then a 64-step divide; a tile with an empty side skips
// the sequence. Per tile the start and calculate states come on top, then
// the result waits in the output register until it is taken. The input is
// not ready from the band-closing beat until the last result of the band has
// been taken. The configuration port is always ready. Reset is synchronous
// and restores the default grid of 640 x 480 pixels with 40 x 80 tiles and
// clears all counts and positions.
// ----------------------------------------------------------------------------
module tile_binary_entropy_flagger (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // pixel[7:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tile_row[11:0], tile_col[16:12], zero_count[41:17], nonzero_count[66:42],
  // entropy[83:67], over_threshold[84], zero fill[87:85]
  output logic [teef_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [teef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [teef_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import teef_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] tile_width;
  logic [DIM_W-1:0] tile_height;
  ent_t             entropy_threshold;

  // Raster position state.
  logic [1:0]       state;
  logic [POS_W-1:0] column_position;
  logic [POS_W-1:0] row_position;
  logic [POS_W-1:0] offset_in_tile;
  logic [COL_W-1:0] current_tile_col;
  logic [DIM_W-1:0] rows_in_band;
  logic [POS_W-1:0] band_index;
  logic [POS_W-1:0] band_row;

  cnt_t zero_counts    [MAX_TILE_COLS];
  cnt_t nonzero_counts [MAX_TILE_COLS];

  // Emission walk over the tiles of a band.
  logic [COL_W-1:0]  tile_idx;
  logic [BASE_W-1:0] tile_base;

  // Output register.
  logic [POS_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  cnt_t             out_zero;
  cnt_t             out_nonzero;
  ent_t             out_entropy;
  logic             out_flag;
  logic             out_last;

  logic [DIM_W-1:0] w, h, tw, th;
  logic             in_beat;
  logic             row_end;
  logic             last_row;
  logic             band_end;
  logic [DIM_W-1:0] rows_inc;
  logic [DIM_W-1:0] offset_inc;
  logic             tile_last;
  logic [BASE_W-1:0] base_next;

  teef_req_t ent_req;
  teef_rsp_t ent_rsp;

  assign w  = clamp_dim(image_width);
  assign h  = clamp_dim(image_height);
  assign tw = clamp_dim(tile_width);
  assign th = clamp_dim(tile_height);

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;

  assign row_end    = !((DIM_W'(column_position) + DIM_W'(1)) < w);
  assign last_row   = (DIM_W'(row_position) + DIM_W'(1)) >= h;
  assign rows_inc   = rows_in_band + DIM_W'(1);
  assign band_end   = row_end && ((rows_inc >= th) || last_row);
  assign offset_inc = DIM_W'(offset_in_tile) + DIM_W'(1);

  // A tile is the band's last when no further tile would start inside the row
  // or when the column index has reached its ceiling.
  assign base_next = tile_base + BASE_W'(tw);
  assign tile_last = (tile_idx == COL_W'(MAX_TILE_COLS - 1)) || (base_next >= BASE_W'(w));

  assign ent_req.start         = (state == ST_START);
  assign ent_req.zero_count    = zero_counts[tile_idx];
  assign ent_req.nonzero_count = nonzero_counts[tile_idx];

  teef_entropy u_entropy (
    .clk (clk),
    .rst (rst),
    .req (ent_req),
    .rsp (ent_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= DIM_W'(640);
      image_height      <= DIM_W'(480);
      tile_width        <= DIM_W'(40);
      tile_height       <= DIM_W'(80);
      entropy_threshold <= ENT_W'(60948);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width       <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height      <= cfg_data[DIM_W-1:0];
        REG_TILE_WIDTH:   tile_width        <= cfg_data[DIM_W-1:0];
        REG_TILE_HEIGHT:  tile_height       <= cfg_data[DIM_W-1:0];
        REG_THRESHOLD:    entropy_threshold <= cfg_data[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      column_position  <= '0;
      row_position     <= '0;
      offset_in_tile   <= '0;
      current_tile_col <= '0;
      rows_in_band     <= '0;
      band_index       <= '0;
      tile_idx         <= '0;
      tile_base        <= '0;
      for (int i = 0; i < MAX_TILE_COLS; i++) begin
        zero_counts[i]    <= '0;
        nonzero_counts[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            // Count the pixel in its tile, saturating at the counter ceiling.
            if (s_tdata == '0) begin
              if (zero_counts[current_tile_col] != COUNT_MAX)
                zero_counts[current_tile_col] <= zero_counts[current_tile_col] + 1'b1;
            end else begin
              if (nonzero_counts[current_tile_col] != COUNT_MAX)
                nonzero_counts[current_tile_col] <= nonzero_counts[current_tile_col] + 1'b1;
            end
            if (!row_end) begin
              column_position <= column_position + 1'b1;
              if (offset_inc >= tw) begin
                offset_in_tile <= '0;
                if (current_tile_col != COL_W'(MAX_TILE_COLS - 1))
                  current_tile_col <= current_tile_col + 1'b1;
              end else begin
                offset_in_tile <= offset_inc[POS_W-1:0];
              end
            end else begin
              column_position  <= '0;
              offset_in_tile   <= '0;
              current_tile_col <= '0;
              row_position     <= last_row ? '0 : row_position + 1'b1;
              if (band_end) begin
                rows_in_band <= '0;
                band_row     <= band_index;
                band_index   <= last_row ? '0 : band_index + 1'b1;
                tile_idx     <= '0;
                tile_base    <= '0;
                state        <= ST_START;
              end else begin
                rows_in_band <= rows_inc;
              end
            end
          end
        end
        ST_START: state <= ST_CALC;
        ST_CALC: begin
          if (ent_rsp.done) begin
            out_row     <= band_row;
            out_col     <= tile_idx;
            out_zero    <= zero_counts[tile_idx];
            out_nonzero <= nonzero_counts[tile_idx];
            out_entropy <= ent_rsp.entropy;
            out_flag    <= ent_rsp.entropy > entropy_threshold;
            out_last    <= tile_last;
            state       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            if (out_last) begin
              for (int i = 0; i < MAX_TILE_COLS; i++) begin
                zero_counts[i]    <= '0;
                nonzero_counts[i] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              tile_idx  <= tile_idx + 1'b1;
              tile_base <= base_next;
              state     <= ST_START;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tlast  = out_last;
  assign m_tdata  = {3'd0, out_flag, out_entropy, out_nonzero, out_zero, out_col, out_row};

  // The input and output sides are never open in the same cycle.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // Taking the last result of a band returns the block to idle, which reopens the input.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not reopened after the band's last result");

  // A reported entropy never exceeds one.
  a_entropy_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_entropy <= ENTROPY_ONE))
    else $error("entropy above one");

  // The flag agrees with the threshold comparison.
  a_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_flag == (out_entropy > entropy_threshold)))
    else $error("threshold flag inconsistent");

endmodule

// File: tb/sv/tile_binary_entropy_flagger_chk.sv
// ----------------------------------------------------------------------------
// tile_binary_entropy_flagger_chk: scoreboard for the tile entropy flagger
// Watches the pixel, result and register channels, keeps its own copy of the
// grid state, forecasts the tile results of every closed band and compares
// each result beat field by field against the oldest forecast.
// ----------------------------------------------------------------------------
module tile_binary_entropy_flagger_chk (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [7:0]                          s_tdata,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [teef_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                m_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [teef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [teef_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  tiles_seen
);
  import teef_pkg::*;

  typedef struct packed {
    logic [2:0]  fill;
    logic        over;
    logic [16:0] entropy;
    logic [24:0] nonzero;
    logic [24:0] zero;
    logic [4:0]  col;
    logic [11:0] row;
  } tile_beat_t;

  typedef struct {
    tile_beat_t beat;
    logic       last;
  } tile_result_t;

  tile_result_t tile_q[$];

  logic [12:0] img_w, img_h, tile_w, tile_h;
  logic [16:0] thresh;
  logic [11:0] col_pos, row_pos, tile_off, band;
  logic [12:0] rows_done;
  logic [4:0]  tile_col;
  logic [24:0] zeros [MAX_TILE_COLS];
  logic [24:0] ones [MAX_TILE_COLS];

  function automatic logic [31:0] dim_eff(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > 13'd4096) return 4096;
    return v;
  endfunction

  // Fixed-point log2 with 32 fraction bits: the integer part is the MSB index,
  // the fraction comes from squaring the normalized mantissa bit by bit.
  function automatic logic [63:0] log2_q32(input logic [31:0] x);
    int k;
    logic [63:0] m, frac;
    k = 0;
    frac = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = 64'(x) << (31 - k);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(k) << 32) | frac;
  endfunction

  function automatic logic [16:0] tile_entropy(input logic [24:0] z, input logic [24:0] c);
    logic [63:0] n, total, parts, h, r;
    if (z == 0 || c == 0) return 0;
    n = 64'(z) + 64'(c);
    total = n * log2_q32(32'(n));
    parts = 64'(z) * log2_q32(32'(z)) + 64'(c) * log2_q32(32'(c));
    if (parts >= total) return 0;
    h = (total - parts) / n;
    r = (h + 64'h8000) >> 16;
    if (r > 65536) r = 65536;
    return r[16:0];
  endfunction

  task automatic clear_grid();
    col_pos = 0; row_pos = 0; tile_off = 0; tile_col = 0; rows_done = 0; band = 0;
    foreach (zeros[i]) begin
      zeros[i] = 0;
      ones[i] = 0;
    end
  endtask

  // Counts one pixel and, when it closes a band, queues one result per tile.
  task automatic count_pixel(input logic [7:0] pix);
    logic [31:0] w, h, tw, th, ncols;
    logic last_row;
    tile_result_t res;
    w = dim_eff(img_w); h = dim_eff(img_h); tw = dim_eff(tile_w); th = dim_eff(tile_h);
    if (pix == 0) begin
      if (zeros[tile_col] != COUNT_MAX) zeros[tile_col]++;
    end else begin
      if (ones[tile_col] != COUNT_MAX) ones[tile_col]++;
    end
    if (32'(col_pos) + 1 < w) begin
      col_pos++;
      tile_off++;
      if (32'(tile_off) >= tw) begin
        tile_off = 0;
        if (tile_col != MAX_TILE_COLS - 1) tile_col++;
      end
      return;
    end
    col_pos = 0; tile_off = 0; tile_col = 0;
    last_row = (32'(row_pos) + 1 >= h);
    rows_done++;
    row_pos = last_row ? 12'd0 : row_pos + 12'd1;
    if (32'(rows_done) < th && !last_row) return;
    ncols = (w + tw - 1) / tw;
    if (ncols > MAX_TILE_COLS) ncols = MAX_TILE_COLS;
    for (int t = 0; t < ncols; t++) begin
      res.beat = '0;
      res.beat.row = band;
      res.beat.col = 5'(t);
      res.beat.zero = zeros[t];
      res.beat.nonzero = ones[t];
      res.beat.entropy = tile_entropy(zeros[t], ones[t]);
      res.beat.over = res.beat.entropy > thresh;
      res.last = (t + 1 == ncols);
      tile_q.push_back(res);
    end
    foreach (zeros[i]) begin
      zeros[i] = 0;
      ones[i] = 0;
    end
    rows_done = 0;
    band = last_row ? 12'd0 : band + 12'd1;
  endtask

  task automatic check_tile(input tile_beat_t got, input logic got_last);
    tile_result_t exp;
    if (tile_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected tile beat %h last %b", $time, got, got_last);
      return;
    end
    exp = tile_q.pop_front();
    if (got !== exp.beat || got_last !== exp.last) begin
      errors++;
      $display("%0t: tile beat mismatch", $time);
      $display("  expected row %0d col %0d z %0d nz %0d ent %0d over %b fill %h last %b",
               exp.beat.row, exp.beat.col, exp.beat.zero, exp.beat.nonzero,
               exp.beat.entropy, exp.beat.over, exp.beat.fill, exp.last);
      $display("  actual   row %0d col %0d z %0d nz %0d ent %0d over %b fill %h last %b",
               got.row, got.col, got.zero, got.nonzero, got.entropy, got.over,
               got.fill, got_last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      img_w = 640; img_h = 480; tile_w = 40; tile_h = 80; thresh = 60948;
      clear_grid();
      tile_q.delete();
      errors = 0;
      tiles_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_w = cfg_data[12:0];
          REG_IMAGE_HEIGHT: img_h = cfg_data[12:0];
          REG_TILE_WIDTH:   tile_w = cfg_data[12:0];
          REG_TILE_HEIGHT:  tile_h = cfg_data[12:0];
          REG_THRESHOLD:    thresh = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        check_tile(tile_beat_t'(m_tdata), m_tlast);
        tiles_seen++;
      end
      if (s_tvalid && s_tready) count_pixel(s_tdata);
    end
    pending = tile_q.size();
  end

endmodule

// File: tb/sv/tile_binary_entropy_flagger_tb.sv
// ----------------------------------------------------------------------------
// tile_binary_entropy_flagger_tb: stimulus and verdict for the tile flagger
// Drives pixel streams through a series of grid settings, from degenerate
// one-pixel images and saturated tile columns to random small grids, with
// random gaps on both channels. A separate checker forecasts and compares.
// ----------------------------------------------------------------------------
module tile_binary_entropy_flagger_tb;
  import teef_pkg::*;

  // Generous bound on the run length; the run closes a few hundred small bands at most.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_PIXELS = 110;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending, tiles_seen;
  int cycles = 0;
  int pixels_sent = 0;
  int settings_used = 0;
  // Percent of cycles in which the pixel sender and the result taker idle.
  int send_idle = 25;
  int take_idle = 76;

  always #2 clk = ~clk;

  tile_binary_entropy_flagger uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tlast, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tile_binary_entropy_flagger_chk chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tlast, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending,
    .tiles_seen
  );

  // The result side stalls at random, independently of the pixel side.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= take_idle);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tiles still expected", cycles, pending);
      $display("tile_binary_entropy_flagger: mismatch");
      $finish;
    end
  end

  // Sends one pixel beat, inserting random idle cycles ahead of it. Valid is
  // left high afterwards so back-to-back beats need no second assignment.
  task automatic send_pixel(input logic [7:0] pix);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // Lets the block drain every tile result before the registers change.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Valid stays high afterwards so consecutive writes need no second
  // assignment in the same step; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_grid(input int w, input int h, input int tw, input int th, input int thr);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_TILE_WIDTH, CFG_DATA_W'(tw));
    write_reg(REG_TILE_HEIGHT, CFG_DATA_W'(th));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly zero or small values so tiles get mixed counts, with full-range
  // values mixed in so every pixel bit toggles.
  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(3))
      0, 1: return 8'd0;
      2: return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int w, h, tw, th, n, rand_sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A few pixels under the reset grid, left mid-row on purpose so the next
    // setting takes effect on a partially filled image.
    send_pixel(8'd0);
    send_pixel(8'hFF);
    send_pixel(8'h55);

    // Zero dimensions act as one: every pixel is a full image with one tile,
    // and a lone pixel always has zero entropy.
    set_grid(0, 0, 0, 0, 0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'hAA);
    send_pixel(8'd1);

    // Half-and-half tiles give an entropy of exactly one, which does not
    // strictly exceed the top threshold.
    set_grid(4, 2, 2, 1, 65536);
    send_pixel(8'd0); send_pixel(8'd7); send_pixel(8'd9); send_pixel(8'd0);
    send_pixel(8'd0); send_pixel(8'd0); send_pixel(8'd128); send_pixel(8'd64);

    // More tile columns than the block holds: the last tile absorbs the rest.
    set_grid(36, 1, 1, 8191, 131071);
    for (int i = 0; i < 36; i++) send_pixel(rand_pixel());

    // Oversized dimensions clamp to the maximum. The long row is left open
    // here and is closed by the first pixel under the next, narrower grid.
    set_grid(8191, 1, 8191, 1, 30000);
    for (int i = 0; i < 40; i++) send_pixel(8'((i % 3 == 0) ? 0 : i));

    // Random small grids. The idle mix moves from receiver-heavy to
    // sender-heavy to none as the random part progresses.
    rand_sent = 0;
    while (rand_sent < RANDOM_PIXELS) begin
      if (rand_sent >= 2 * RANDOM_PIXELS / 3) begin
        send_idle = 0; take_idle = 0;
      end else if (rand_sent >= RANDOM_PIXELS / 3) begin
        send_idle = 76; take_idle = 25;
      end
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 5);
      tw = $urandom_range(1, w + 1);
      th = $urandom_range(1, h + 1);
      set_grid(w, h, tw, th, $urandom_range(65536));
      n = w * h * $urandom_range(1, 2) + $urandom_range(w);
      for (int i = 0; i < n && rand_sent < RANDOM_PIXELS; i++) begin
        send_pixel(rand_pixel());
        rand_sent++;
        // Hold the stream once until every forecast tile has come back.
        if (rand_sent == RANDOM_PIXELS / 2) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d pixels over %0d grid settings, %0d tile results checked",
             pixels_sent, settings_used, tiles_seen);
    $display("including one-pixel images, saturated tile columns and clamped dimensions");
    if (errors == 0 && pending == 0) begin
      $display("tile_binary_entropy_flagger: match");
    end else begin
      $display("tile_binary_entropy_flagger: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/teef_pkg.sv
rtl/teef_mul.sv
rtl/teef_entropy.sv
rtl/tile_binary_entropy_flagger.sv
tb/sv/tile_binary_entropy_flagger_chk.sv
tb/sv/tile_binary_entropy_flagger_tb.sv
